### hdl/escal_pkg.sv
package escal_pkg;

	// field widths
	localparam int unsigned SECS_W  = 32;
	localparam int unsigned DAYS_W  = 16;
	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;

	// time constants
	localparam logic [SECS_W-1:0] SECS_PER_DAY  = 32'd86400;
	localparam logic [SECS_W-1:0] SECS_PER_HOUR = 32'd3600;
	localparam logic [SECS_W-1:0] SECS_PER_MIN  = 32'd60;

	// reciprocal multipliers for the constant divisions, applied after the
	// power-of-two factor of each divisor is shifted out
	localparam int unsigned DAY_PRE    = 7;               // 86400 = 675 << 7
	localparam int unsigned DAY_SHR    = 35;
	localparam logic [25:0] DAY_RECIP  = 26'd50903317;    // ceil(2^35 / 675)
	localparam int unsigned HOUR_PRE   = 4;               // 3600 = 225 << 4
	localparam int unsigned HOUR_SHR   = 21;
	localparam logic [13:0] HOUR_RECIP = 14'd9321;        // ceil(2^21 / 225)
	localparam int unsigned MIN_PRE    = 2;               // 60 = 15 << 2
	localparam int unsigned MIN_SHR    = 14;
	localparam logic [10:0] MIN_RECIP  = 11'd1093;        // ceil(2^14 / 15)

	// calendar constants
	localparam logic [YEAR_W-1:0]  BASE_YEAR   = 12'd1970;
	localparam logic [YEAR_W-1:0]  YEAR_CAP    = 12'd4095;
	localparam logic [YEAR_W-1:0]  RANGE_LOW   = 12'd2000;
	localparam logic [YEAR_W-1:0]  RANGE_HIGH  = 12'd2099;
	localparam logic [6:0]         BASE_MOD100 = 7'd70;
	localparam logic [8:0]         BASE_MOD400 = 9'd370;
	localparam logic [6:0]         LAST_MOD100 = 7'd99;
	localparam logic [8:0]         LAST_MOD400 = 9'd399;
	localparam logic [DAYS_W-1:0]  DAYS_LEAP   = 16'd366;
	localparam logic [DAYS_W-1:0]  DAYS_COMMON = 16'd365;
	localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd0;
	localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAYS,
		ST_HOURS,
		ST_MINS,
		ST_YEARS,
		ST_MONTHS,
		ST_WRITE
	} state_t;

	typedef enum logic [1:0] {
		DIV_DAY,
		DIV_HOUR,
		DIV_MIN
	} div_sel_t;

	// div_last selects the remainder cycle of a division, else the quotient
	typedef struct packed {
		logic              load;
		logic              div_en;
		div_sel_t          div_sel;
		logic              div_last;
		logic              year_en;
		logic              month_en;
		logic              publish;
	} cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
	} status_t;

	// days in month, index 0 is january
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] idx,
		input logic leap);
		logic [DAY_W-1:0] n;
		unique case (idx)
			4'd0:    n = 5'd31;
			4'd1:    n = leap ? 5'd29 : 5'd28;
			4'd2:    n = 5'd31;
			4'd3:    n = 5'd30;
			4'd4:    n = 5'd31;
			4'd5:    n = 5'd30;
			4'd6:    n = 5'd31;
			4'd7:    n = 5'd31;
			4'd8:    n = 5'd30;
			4'd9:    n = 5'd31;
			4'd10:   n = 5'd30;
			4'd11:   n = 5'd31;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

### hdl/escal_dp.sv
module escal_dp
	import escal_pkg::*;
(
	input  logic                clk,
	input  logic [SECS_W-1:0]   epoch_seconds,
	input  cmd_t                cmd,
	output status_t             status,
	output logic [YEAR_W-1:0]   year,
	output logic [MONTH_W-1:0]  month,
	output logic [DAY_W-1:0]    day,
	output logic [HOUR_W-1:0]   hour,
	output logic [MIN_W-1:0]    minute,
	output logic [SEC_W-1:0]    second,
	output logic                in_range
);

	logic [SECS_W-1:0]  rem_q;
	logic [DAYS_W-1:0]  days_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [MIN_W-1:0]   minute_q;
	logic [SEC_W-1:0]   second_q;
	logic [YEAR_W-1:0]  year_q;
	logic [6:0]         mod100_q;
	logic [8:0]         mod400_q;
	logic [MONTH_W-1:0] month_q;

	logic [50:0]        day_prod;
	logic [26:0]        hour_prod;
	logic [20:0]        min_prod;
	logic [SECS_W-1:0]  div_sub;
	logic [SECS_W-1:0]  rem_next;
	logic               leap;
	logic [DAYS_W-1:0]  year_len;
	logic [DAYS_W-1:0]  mon_len;

	// quotients by reciprocal multiplication, remainder by multiply and subtract
	always_comb begin
		day_prod  = 51'(rem_q[SECS_W-1:DAY_PRE]) * 51'(DAY_RECIP);
		hour_prod = 27'(rem_q[16:HOUR_PRE]) * 27'(HOUR_RECIP);
		min_prod  = 21'(rem_q[11:MIN_PRE]) * 21'(MIN_RECIP);
		unique case (cmd.div_sel)
			DIV_DAY:  div_sub = SECS_W'(days_q) * SECS_PER_DAY;
			DIV_HOUR: div_sub = SECS_W'(hour_q) * SECS_PER_HOUR;
			DIV_MIN:  div_sub = SECS_W'(minute_q) * SECS_PER_MIN;
			default:  div_sub = '0;
		endcase
		rem_next = rem_q - div_sub;
	end

	// leap rule from running year residues
	always_comb begin
		leap     = (year_q[1:0] == 2'b00) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
		year_len = leap ? DAYS_LEAP : DAYS_COMMON;
		mon_len  = DAYS_W'(month_days(month_q, leap));
		status.year_done  = (days_q < year_len) || (year_q == YEAR_CAP);
		status.month_done = (month_q == MONTH_DEC) || (days_q < mon_len);
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q    <= epoch_seconds;
			year_q   <= BASE_YEAR;
			mod100_q <= BASE_MOD100;
			mod400_q <= BASE_MOD400;
			month_q  <= MONTH_JAN;
		end
		if (cmd.div_en) begin
			if (cmd.div_last) begin
				rem_q <= rem_next;
				if (cmd.div_sel == DIV_MIN) begin
					second_q <= rem_next[SEC_W-1:0];
				end
			end else begin
				unique case (cmd.div_sel)
					DIV_DAY:  days_q   <= day_prod[DAY_SHR +: DAYS_W];
					DIV_HOUR: hour_q   <= hour_prod[HOUR_SHR +: HOUR_W];
					DIV_MIN:  minute_q <= min_prod[MIN_SHR +: MIN_W];
					default: ;
				endcase
			end
		end
		// one whole year per cycle
		if (cmd.year_en && !status.year_done) begin
			days_q   <= days_q - year_len;
			year_q   <= year_q + YEAR_W'(1);
			mod100_q <= (mod100_q == LAST_MOD100) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == LAST_MOD400) ? 9'd0 : mod400_q + 9'd1;
		end
		// one whole month per cycle
		if (cmd.month_en && !status.month_done) begin
			days_q  <= days_q - mon_len;
			month_q <= month_q + MONTH_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			year     <= year_q;
			month    <= month_q + MONTH_W'(1);
			day      <= days_q[DAY_W-1:0] + DAY_W'(1);
			hour     <= hour_q;
			minute   <= minute_q;
			second   <= second_q;
			in_range <= (year_q >= RANGE_LOW) && (year_q <= RANGE_HIGH);
		end
	end

endmodule

### hdl/escal_ctrl.sv
module escal_ctrl
	import escal_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   phase_q, phase_d;
	logic   out_valid_q, out_valid_d;

	// state, division phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// sequencer, each division runs a quotient step then a remainder step
	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		cmd          = '0;
		cmd.div_sel  = DIV_DAY;
		cmd.div_last = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DAYS;
					phase_d  = 1'b0;
				end
			end
			ST_DAYS: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = DIV_DAY;
				if (cmd.div_last) begin
					state_d = ST_HOURS;
					phase_d = 1'b0;
				end else begin
					phase_d = 1'b1;
				end
			end
			ST_HOURS: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = DIV_HOUR;
				if (cmd.div_last) begin
					state_d = ST_MINS;
					phase_d = 1'b0;
				end else begin
					phase_d = 1'b1;
				end
			end
			ST_MINS: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = DIV_MIN;
				if (cmd.div_last) begin
					state_d = ST_YEARS;
					phase_d = 1'b0;
				end else begin
					phase_d = 1'b1;
				end
			end
			ST_YEARS: begin
				cmd.year_en = 1'b1;
				if (status.year_done) begin
					state_d = ST_MONTHS;
				end
			end
			ST_MONTHS: begin
				cmd.month_en = 1'b1;
				if (status.month_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output beat bookkeeping
	always_comb begin
		if (cmd.publish) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

endmodule

### hdl/epoch_seconds_to_calendar_unit.sv
// Unix seconds to Gregorian calendar date and time.
// Input channel: in_valid / in_stall carry epoch_seconds; a beat is taken
// when in_valid is high and in_stall is low. in_stall is high while an item
// is being converted, so one item is in work at a time.
// Output channel: out_valid / out_stall carry year, month, day, hour,
// minute, second and in_range (year 2000..2099), held in an output register.
// A new item is taken while a finished result still waits on out_stall.
// From the input beat to out_valid, the item first has its seconds split
// into days, hours, minutes and seconds by reciprocal multiplication (a
// quotient step and a remainder step per divisor); then whole years are
// walked from 1970, then whole months, and the result is loaded into the
// output register. The next input is taken only after the result enters
// the register, so a new item is not taken before the last one is finished.
// If the receiver stalls with a result already held, the finished item
// waits in the datapath and in_stall stays high until the register frees.
// Reset (arst_n low) empties the output register and returns to idle.
module epoch_seconds_to_calendar_unit
	import escal_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SECS_W-1:0]   epoch_seconds,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [YEAR_W-1:0]   year,
	output logic [MONTH_W-1:0]  month,
	output logic [DAY_W-1:0]    day,
	output logic [HOUR_W-1:0]   hour,
	output logic [MIN_W-1:0]    minute,
	output logic [SEC_W-1:0]    second,
	output logic                in_range
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	escal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// division, year and month walk, output register
	escal_dp u_dp (
		.clk           (clk),
		.epoch_seconds (epoch_seconds),
		.cmd           (cmd),
		.status        (status),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.in_range      (in_range)
	);

`ifndef SYNTHESIS
	// a result is loaded only after an item was being worked on
	a_publish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> in_stall)
		else $error("result loaded while idle");

	// a new result never loads while an unaccepted result is held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid || !out_stall))
		else $error("held result overwritten");

	// delivered month, hour, minute and second stay in range and day is at least 1
	a_fields_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1
			&& hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
		else $error("calendar field out of range");

	// item intake only leaves idle through the day quotient
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (in_stall && cmd.div_en && cmd.div_sel == DIV_DAY
			&& !cmd.div_last))
		else $error("conversion did not start with day division");
`endif

endmodule
